>>> hw/rtl/rv32i_instruction_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// RV32I instruction decoder assertion macros
// Concurrent assertion helpers clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RV32I_INSTRUCTION_DECODER_TOP_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RVID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvid: same-cycle check failed");

// Next-cycle implication.
`define RVID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvid: next-cycle check failed");

`endif

>>> hw/rtl/rvid_pkg.sv
// ----------------------------------------------------------------------------
// RV32I instruction decoder package
// Opcode, format and operation codes, and the funct3 lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package rvid_pkg;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] FMT_R = 3'd0;
  localparam logic [2:0] FMT_I = 3'd1;
  localparam logic [2:0] FMT_S = 3'd2;
  localparam logic [2:0] FMT_B = 3'd3;
  localparam logic [2:0] FMT_U = 3'd4;
  localparam logic [2:0] FMT_J = 3'd5;
  localparam logic [2:0] FMT_X = 3'd6;

  localparam logic [5:0] OP_UNKNOWN   = 6'd0;
  localparam logic [5:0] OP_UNMATCHED = 6'd1;
  localparam logic [5:0] OP_ADD   = 6'd2;
  localparam logic [5:0] OP_AND   = 6'd3;
  localparam logic [5:0] OP_OR    = 6'd4;
  localparam logic [5:0] OP_XOR   = 6'd5;
  localparam logic [5:0] OP_SLL   = 6'd6;
  localparam logic [5:0] OP_SRL   = 6'd7;
  localparam logic [5:0] OP_SLT   = 6'd8;
  localparam logic [5:0] OP_SLTU  = 6'd9;
  localparam logic [5:0] OP_SUB   = 6'd10;
  localparam logic [5:0] OP_SRA   = 6'd11;
  localparam logic [5:0] OP_ADDI  = 6'd12;
  localparam logic [5:0] OP_ANDI  = 6'd13;
  localparam logic [5:0] OP_ORI   = 6'd14;
  localparam logic [5:0] OP_XORI  = 6'd15;
  localparam logic [5:0] OP_SLTI  = 6'd16;
  localparam logic [5:0] OP_SLTIU = 6'd17;
  localparam logic [5:0] OP_SLLI  = 6'd18;
  localparam logic [5:0] OP_SRLI  = 6'd19;
  localparam logic [5:0] OP_LW    = 6'd20;
  localparam logic [5:0] OP_LB    = 6'd21;
  localparam logic [5:0] OP_LBU   = 6'd22;
  localparam logic [5:0] OP_LHU   = 6'd23;
  localparam logic [5:0] OP_JALR  = 6'd24;
  localparam logic [5:0] OP_SW    = 6'd25;
  localparam logic [5:0] OP_SB    = 6'd26;
  localparam logic [5:0] OP_SH    = 6'd27;
  localparam logic [5:0] OP_BEQ   = 6'd28;
  localparam logic [5:0] OP_BNE   = 6'd29;
  localparam logic [5:0] OP_BLT   = 6'd30;
  localparam logic [5:0] OP_BGE   = 6'd31;
  localparam logic [5:0] OP_BLTU  = 6'd32;
  localparam logic [5:0] OP_BGEU  = 6'd33;
  localparam logic [5:0] OP_LUI   = 6'd34;
  localparam logic [5:0] OP_AUIPC = 6'd35;
  localparam logic [5:0] OP_JAL   = 6'd36;

  typedef enum logic [3:0] {
    KIND_OP,
    KIND_OPIMM,
    KIND_LOAD,
    KIND_JALR,
    KIND_STORE,
    KIND_BRANCH,
    KIND_LUI,
    KIND_AUIPC,
    KIND_JAL,
    KIND_NONE
  } kind_t;

  function automatic kind_t opcode_kind(input logic [6:0] opc);
    kind_t k;
    unique case (opc)
      OPC_OP:     k = KIND_OP;
      OPC_OPIMM:  k = KIND_OPIMM;
      OPC_LOAD:   k = KIND_LOAD;
      OPC_JALR:   k = KIND_JALR;
      OPC_STORE:  k = KIND_STORE;
      OPC_BRANCH: k = KIND_BRANCH;
      OPC_LUI:    k = KIND_LUI;
      OPC_AUIPC:  k = KIND_AUIPC;
      OPC_JAL:    k = KIND_JAL;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] r_base_op(input logic [2:0] f3);
    logic [5:0] op;
    unique case (f3)
      3'd0:    op = OP_ADD;
      3'd1:    op = OP_SLL;
      3'd2:    op = OP_SLT;
      3'd3:    op = OP_SLTU;
      3'd4:    op = OP_XOR;
      3'd5:    op = OP_SRL;
      3'd6:    op = OP_OR;
      default: op = OP_AND;
    endcase
    return op;
  endfunction

  function automatic logic [5:0] r_alt_op(input logic [2:0] f3);
    logic [5:0] op;
    unique case (f3)
      3'd0:    op = OP_SUB;
      3'd5:    op = OP_SRA;
      default: op = OP_UNMATCHED;
    endcase
    return op;
  endfunction

  function automatic logic [5:0] opimm_op(input logic [2:0] f3);
    logic [5:0] op;
    unique case (f3)
      3'd0:    op = OP_ADDI;
      3'd1:    op = OP_SLLI;
      3'd2:    op = OP_SLTI;
      3'd3:    op = OP_SLTIU;
      3'd4:    op = OP_XORI;
      3'd5:    op = OP_SRLI;
      3'd6:    op = OP_ORI;
      default: op = OP_ANDI;
    endcase
    return op;
  endfunction

  function automatic logic [5:0] load_op(input logic [2:0] f3);
    logic [5:0] op;
    unique case (f3)
      3'd0:    op = OP_LB;
      3'd2:    op = OP_LW;
      3'd4:    op = OP_LBU;
      3'd5:    op = OP_LHU;
      default: op = OP_UNMATCHED;
    endcase
    return op;
  endfunction

  function automatic logic [5:0] store_op(input logic [2:0] f3);
    logic [5:0] op;
    unique case (f3)
      3'd0:    op = OP_SB;
      3'd1:    op = OP_SH;
      3'd2:    op = OP_SW;
      default: op = OP_UNMATCHED;
    endcase
    return op;
  endfunction

  function automatic logic [5:0] branch_op(input logic [2:0] f3);
    logic [5:0] op;
    unique case (f3)
      3'd0:    op = OP_BEQ;
      3'd1:    op = OP_BNE;
      3'd4:    op = OP_BLT;
      3'd5:    op = OP_BGE;
      3'd6:    op = OP_BLTU;
      3'd7:    op = OP_BGEU;
      default: op = OP_UNMATCHED;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rv32i_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// RV32I instruction decoder
// Three-stage pipelined decoder of RV32I instruction words into format,
// operation, register fields, funct fields and the sign-extended immediate.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   in_instruction_word
//   out      out_valid / out_ready out_format_class .. out_immediate
//
// An item can be accepted every cycle while in_ready is high. Its result
// passes through the stage-one and stage-two registers to the output register.
// Stage one classifies the major opcode, stage two looks up format, operation
// and funct7, stage three assembles the immediate into the output register.
// A stall holds each full stage in place; empty stages still fill.
// Reset clears the stage valid bits only.
`default_nettype none

`include "rv32i_instruction_decoder_top_assert.svh"

module rv32i_instruction_decoder_top
  import rvid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_instruction_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_format_class,
  output logic [5:0]         out_operation,
  output logic [6:0]         out_major_opcode,
  output logic [4:0]         out_dest_reg,
  output logic [4:0]         out_src_reg_one,
  output logic [4:0]         out_src_reg_two,
  output logic [2:0]         out_func_three,
  output logic [6:0]         out_func_seven,
  output logic signed [31:0] out_immediate
);

  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;

  logic [31:0] s1_word_r;
  kind_t       s1_kind_r;

  logic [31:0] s2_word_r;
  logic [2:0]  s2_fmt_r;
  logic [5:0]  s2_op_r;
  logic [6:0]  s2_f7_r;

  logic [24:0]        s3_word_r;
  logic [2:0]         s3_fmt_r;
  logic [5:0]         s3_op_r;
  logic [6:0]         s3_f7_r;
  logic signed [31:0] s3_imm_r;

  logic [2:0]         s2_fmt_nxt;
  logic [5:0]         s2_op_nxt;
  logic [6:0]         s2_f7_nxt;
  logic signed [31:0] s3_imm_nxt;

  assign s3_rdy   = !s3_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_word_r <= in_instruction_word;
      s1_kind_r <= opcode_kind(in_instruction_word[6:0]);
    end
  end

  always_comb begin
    s2_fmt_nxt = FMT_X;
    s2_op_nxt  = OP_UNKNOWN;
    s2_f7_nxt  = 7'd0;
    unique case (s1_kind_r)
      KIND_OP: begin
        s2_fmt_nxt = FMT_R;
        s2_f7_nxt  = s1_word_r[31:25];
        if (s1_word_r[31:25] == F7_BASE) begin
          s2_op_nxt = r_base_op(s1_word_r[14:12]);
        end else if (s1_word_r[31:25] == F7_ALT) begin
          s2_op_nxt = r_alt_op(s1_word_r[14:12]);
        end else begin
          s2_op_nxt = OP_UNMATCHED;
        end
      end
      KIND_OPIMM: begin
        s2_fmt_nxt = FMT_I;
        s2_op_nxt  = opimm_op(s1_word_r[14:12]);
        if (s1_word_r[13:12] == 2'b01) begin
          s2_f7_nxt = s1_word_r[31:25];
        end
      end
      KIND_LOAD: begin
        s2_fmt_nxt = FMT_I;
        s2_op_nxt  = load_op(s1_word_r[14:12]);
      end
      KIND_JALR: begin
        s2_fmt_nxt = FMT_I;
        s2_op_nxt  = OP_JALR;
      end
      KIND_STORE: begin
        s2_fmt_nxt = FMT_S;
        s2_op_nxt  = store_op(s1_word_r[14:12]);
      end
      KIND_BRANCH: begin
        s2_fmt_nxt = FMT_B;
        s2_op_nxt  = branch_op(s1_word_r[14:12]);
      end
      KIND_LUI: begin
        s2_fmt_nxt = FMT_U;
        s2_op_nxt  = OP_LUI;
      end
      KIND_AUIPC: begin
        s2_fmt_nxt = FMT_U;
        s2_op_nxt  = OP_AUIPC;
      end
      KIND_JAL: begin
        s2_fmt_nxt = FMT_J;
        s2_op_nxt  = OP_JAL;
      end
      default: begin
        s2_fmt_nxt = FMT_X;
        s2_op_nxt  = OP_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_word_r <= s1_word_r;
      s2_fmt_r  <= s2_fmt_nxt;
      s2_op_r   <= s2_op_nxt;
      s2_f7_r   <= s2_f7_nxt;
    end
  end

  always_comb begin
    case (s2_fmt_r)
      FMT_I: s3_imm_nxt = {{20{s2_word_r[31]}}, s2_word_r[31:20]};
      FMT_S: s3_imm_nxt = {{20{s2_word_r[31]}}, s2_word_r[31:25], s2_word_r[11:7]};
      FMT_B: s3_imm_nxt = {{19{s2_word_r[31]}}, s2_word_r[31], s2_word_r[7],
                           s2_word_r[30:25], s2_word_r[11:8], 1'b0};
      FMT_U: s3_imm_nxt = {s2_word_r[31:12], 12'd0};
      FMT_J: s3_imm_nxt = {{11{s2_word_r[31]}}, s2_word_r[31], s2_word_r[19:12],
                           s2_word_r[20], s2_word_r[30:21], 1'b0};
      default: s3_imm_nxt = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_word_r <= s2_word_r[24:0];
      s3_fmt_r  <= s2_fmt_r;
      s3_op_r   <= s2_op_r;
      s3_f7_r   <= s2_f7_r;
      s3_imm_r  <= s3_imm_nxt;
    end
  end

  assign out_valid        = s3_v_r;
  assign out_format_class = s3_fmt_r;
  assign out_operation    = s3_op_r;
  assign out_major_opcode = s3_word_r[6:0];
  assign out_dest_reg     = s3_word_r[11:7];
  assign out_func_three   = s3_word_r[14:12];
  assign out_src_reg_one  = s3_word_r[19:15];
  assign out_src_reg_two  = s3_word_r[24:20];
  assign out_func_seven   = s3_f7_r;
  assign out_immediate    = s3_imm_r;

  `RVID_ASSERT_NOW(a_unknown_clean, out_valid && (out_format_class == FMT_X),
    (out_operation == OP_UNKNOWN) && (out_immediate == 32'sd0) && (out_func_seven == 7'd0))
  `RVID_ASSERT_NOW(a_rtype_no_imm, out_valid && (out_format_class == FMT_R),
    out_immediate == 32'sd0)
  `RVID_ASSERT_NOW(a_f7_only_defined, out_valid && (out_func_seven != 7'd0),
    (out_format_class == FMT_R) || (out_operation == OP_SLLI) || (out_operation == OP_SRLI))
  `RVID_ASSERT_NEXT(a_s2_holds, s2_v_r && s3_v_r && !out_ready,
    s2_v_r && $stable(s2_word_r) && $stable(s2_op_r))
  `RVID_ASSERT_NEXT(a_s1_holds, s1_v_r && !s2_rdy,
    s1_v_r && $stable(s1_word_r))

endmodule

`default_nettype wire
